[hdl/phb_pkg.sv]
// ----------------------------------------------------------------------------
// phb_pkg: shared types and tables for the PLCP header builder
// Rate codes, signal codes, service bytes, the rate lookup table and the
// constants of the divide-by-eleven unit.
// ----------------------------------------------------------------------------
package phb_pkg;

	// Field widths
	localparam int OCTET_W = 12;
	localparam int RATE_W  = 7;
	localparam int WORD_W  = 32;
	localparam int SIG_W   = 8;
	localparam int DUR_W   = 16;

	// Stream word widths (fields packed from the lowest bit, padded to bytes)
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 3;

	// Rate codes in 500 kbps units
	localparam logic [RATE_W-1:0] RATE_1M   = 7'd2;
	localparam logic [RATE_W-1:0] RATE_2M   = 7'd4;
	localparam logic [RATE_W-1:0] RATE_5M5  = 7'd11;
	localparam logic [RATE_W-1:0] RATE_11M  = 7'd22;
	localparam logic [RATE_W-1:0] RATE_6M   = 7'd12;
	localparam logic [RATE_W-1:0] RATE_9M   = 7'd18;
	localparam logic [RATE_W-1:0] RATE_12M  = 7'd24;
	localparam logic [RATE_W-1:0] RATE_18M  = 7'd36;
	localparam logic [RATE_W-1:0] RATE_24M  = 7'd48;
	localparam logic [RATE_W-1:0] RATE_36M  = 7'd72;
	localparam logic [RATE_W-1:0] RATE_48M  = 7'd96;
	localparam logic [RATE_W-1:0] RATE_54M  = 7'd108;
	localparam logic [RATE_W-1:0] RATE_NONE = 7'd0;

	// CCK signal bytes
	localparam logic [SIG_W-1:0] SIG_1M  = 8'h0A;
	localparam logic [SIG_W-1:0] SIG_2M  = 8'h14;
	localparam logic [SIG_W-1:0] SIG_5M5 = 8'h37;
	localparam logic [SIG_W-1:0] SIG_11M = 8'h6E;

	// OFDM signal rate codes
	localparam logic [SIG_W-1:0] SIG_6M  = 8'h0B;
	localparam logic [SIG_W-1:0] SIG_9M  = 8'h0F;
	localparam logic [SIG_W-1:0] SIG_12M = 8'h0A;
	localparam logic [SIG_W-1:0] SIG_18M = 8'h0E;
	localparam logic [SIG_W-1:0] SIG_24M = 8'h09;
	localparam logic [SIG_W-1:0] SIG_36M = 8'h0D;
	localparam logic [SIG_W-1:0] SIG_48M = 8'h08;
	localparam logic [SIG_W-1:0] SIG_54M = 8'h0C;

	// CCK service bytes
	localparam logic [7:0] SERVICE_PLAIN   = 8'h04;
	localparam logic [7:0] SERVICE_LEN_EXT = 8'h84;

	// Divide by eleven: q = (x * RECIP_11) >> DIV11_SHIFT, then one correction
	localparam int               DIV11_X_W   = 15;
	localparam int               DIV11_SHIFT = 18;
	localparam int               DIV11_P_W   = 30;
	localparam logic [14:0]      RECIP_11    = 15'((1 << DIV11_SHIFT) / 11);
	localparam logic [4:0]       DIVISOR_11  = 5'd11;
	localparam int               Q8_W        = 12;
	localparam int               Q16_W       = 13;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_CCK  = 2'd1,
		KIND_OFDM = 2'd2
	} rate_kind_t;

	typedef struct packed {
		rate_kind_t             kind;
		logic [SIG_W-1:0]       sig;
		logic [RATE_W-1:0]      code;
		logic [RATE_W-1:0]      fb;
	} rate_info_t;

	// Quotients and remainders of octets*8/11 and octets*16/11
	typedef struct packed {
		logic [Q8_W-1:0]  q8;
		logic [3:0]       r8;
		logic [Q16_W-1:0] q16;
		logic [3:0]       r16;
	} div11_t;

	function automatic rate_info_t lookup_rate(input logic [RATE_W-1:0] rate);
		rate_info_t r;
		r.kind = KIND_NONE;
		r.sig  = '0;
		r.code = rate;
		r.fb   = RATE_NONE;
		case (rate)
			RATE_1M: begin
				r.kind = KIND_CCK;  r.sig = SIG_1M;  r.fb = RATE_1M;
			end
			RATE_2M: begin
				r.kind = KIND_CCK;  r.sig = SIG_2M;  r.fb = RATE_1M;
			end
			RATE_5M5: begin
				r.kind = KIND_CCK;  r.sig = SIG_5M5; r.fb = RATE_2M;
			end
			RATE_11M: begin
				r.kind = KIND_CCK;  r.sig = SIG_11M; r.fb = RATE_5M5;
			end
			RATE_6M: begin
				r.kind = KIND_OFDM; r.sig = SIG_6M;  r.fb = RATE_5M5;
			end
			RATE_9M: begin
				r.kind = KIND_OFDM; r.sig = SIG_9M;  r.fb = RATE_6M;
			end
			RATE_12M: begin
				r.kind = KIND_OFDM; r.sig = SIG_12M; r.fb = RATE_9M;
			end
			RATE_18M: begin
				r.kind = KIND_OFDM; r.sig = SIG_18M; r.fb = RATE_12M;
			end
			RATE_24M: begin
				r.kind = KIND_OFDM; r.sig = SIG_24M; r.fb = RATE_18M;
			end
			RATE_36M: begin
				r.kind = KIND_OFDM; r.sig = SIG_36M; r.fb = RATE_24M;
			end
			RATE_48M: begin
				r.kind = KIND_OFDM; r.sig = SIG_48M; r.fb = RATE_36M;
			end
			RATE_54M: begin
				r.kind = KIND_OFDM; r.sig = SIG_54M; r.fb = RATE_48M;
			end
			default: begin
				r.kind = KIND_NONE;
			end
		endcase
		return r;
	endfunction

endpackage

[hdl/phb_div11.sv]
// ----------------------------------------------------------------------------
// phb_div11: divide the frame bit count by eleven
// Reciprocal multiply with one correction step gives octets*8/11; the
// octets*16/11 result follows by doubling quotient and remainder.
// ----------------------------------------------------------------------------
module phb_div11 import phb_pkg::*; (
	input  logic [OCTET_W-1:0] octets,
	output div11_t             res
);

	logic [DIV11_X_W-1:0] x8;
	logic [DIV11_P_W-1:0] prod;
	logic [Q8_W-1:0]      q_est;
	logic [DIV11_X_W-1:0] q_times_11;
	logic [DIV11_X_W-1:0] r_wide;
	logic [4:0]           r_est;
	logic [4:0]           r16_raw;

	// Estimate the quotient, never above the true value
	assign x8    = {octets, 3'b000};
	assign prod  = DIV11_P_W'(x8) * DIV11_P_W'(RECIP_11);
	assign q_est = prod[DIV11_SHIFT +: Q8_W];

	// Remainder of the estimate through shift and add
	assign q_times_11 = DIV11_X_W'({q_est, 3'b000}) + DIV11_X_W'({q_est, 1'b0})
		+ DIV11_X_W'(q_est);
	assign r_wide = x8 - q_times_11;
	assign r_est  = r_wide[4:0];

	// Correct the estimate, then double for the sixteen-times count
	always_comb begin
		if (r_est >= DIVISOR_11) begin
			res.q8 = q_est + Q8_W'(1);
			res.r8 = 4'(r_est - DIVISOR_11);
		end else begin
			res.q8 = q_est;
			res.r8 = r_est[3:0];
		end
		r16_raw = {res.r8, 1'b0};
		if (r16_raw >= DIVISOR_11) begin
			res.q16 = {res.q8, 1'b1};
			res.r16 = 4'(r16_raw - DIVISOR_11);
		end else begin
			res.q16 = {res.q8, 1'b0};
			res.r16 = r16_raw[3:0];
		end
	end

endmodule

[hdl/phb_hdr.sv]
// ----------------------------------------------------------------------------
// phb_hdr: assemble one PLCP header word
// OFDM: rate code with the length at bit 5. CCK: signal byte, service byte
// and the rounded-up duration in microseconds.
// ----------------------------------------------------------------------------
module phb_hdr import phb_pkg::*; (
	input  logic [OCTET_W-1:0] octets,
	input  rate_info_t         info,
	input  div11_t             div,
	output logic [WORD_W-1:0]  header
);

	logic [DUR_W-1:0] dur;
	logic [7:0]       service;

	// Duration and service byte for the CCK rates
	always_comb begin
		dur     = '0;
		service = SERVICE_PLAIN;
		case (info.code)
			RATE_1M: begin
				dur = DUR_W'({octets, 3'b000});
			end
			RATE_2M: begin
				dur = DUR_W'({octets, 2'b00});
			end
			RATE_5M5: begin
				dur = DUR_W'(div.q16) + DUR_W'(div.r16 != 4'd0);
			end
			RATE_11M: begin
				dur = DUR_W'(div.q8) + DUR_W'(div.r8 != 4'd0);
				if (div.r8 != 4'd0 && div.r8 < 4'd4) begin
					service = SERVICE_LEN_EXT;
				end
			end
			default: begin
				dur = '0;
			end
		endcase
	end

	// Pick the layout by rate kind
	always_comb begin
		case (info.kind)
			KIND_OFDM: header = {15'b0, octets, 1'b0, info.sig[3:0]};
			KIND_CCK:  header = {dur, service, info.sig};
			default:   header = '0;
		endcase
	end

endmodule

[hdl/wlan_plcp_header_builder_top.sv]
// ----------------------------------------------------------------------------
// wlan_plcp_header_builder_top: PLCP header word builder
// Builds the header word for a rate and length, plus the fallback rate and
// its header word, one request per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one word per request, octet_count and rate_code.
//   Output stream m_axis_*: one word per request with both header words and
//   the fallback rate in tdata, the OFDM and bad-rate flags in tuser.
//   Path: input register, one pass of header logic, then the result
//   register driving m_axis_tvalid. Throughput: one request per cycle
//   unless the output stalls; the longest path is the reciprocal multiply
//   of the divide-by-eleven unit feeding the result register.
//   An unsupported rate code returns zero words, zero fallback rate and the
//   bad-rate flag set.
//   Reset clears both valid flags; nothing is pending afterwards.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more request; s_axis_tready then drops
//   until the output is taken.
// ----------------------------------------------------------------------------
module wlan_plcp_header_builder_top import phb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [11:0] octet_count, [18:12] rate_code, [23:19] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [31:0] header_word, [38:32] fallback_rate,
	// [70:39] fallback_header_word, [71] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [0] primary_ofdm, [1] fallback_ofdm, [2] bad_rate
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	logic                  valid_s1;
	logic [OCTET_W-1:0]    octets_s1;
	logic [RATE_W-1:0]     rate_s1;
	logic                  valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;
	logic [OUT_USER_W-1:0] user_s2;

	logic                  adv_s2;
	logic                  adv_s1;
	rate_info_t            prim_info;
	rate_info_t            fb_info;
	div11_t                div;
	logic [WORD_W-1:0]     prim_header;
	logic [WORD_W-1:0]     fb_header;
	logic                  bad_rate;

	// Handshake: each stage moves when the one after it is free
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			octets_s1 <= s_axis_tdata[OCTET_W-1:0];
			rate_s1   <= s_axis_tdata[OCTET_W +: RATE_W];
		end
	end

	// Look up the given rate and its fallback
	assign prim_info = lookup_rate(rate_s1);
	assign fb_info   = lookup_rate(prim_info.fb);
	assign bad_rate  = (prim_info.kind == KIND_NONE);

	// Shared divide by eleven for both header words
	phb_div11 u_div11 (
		.octets (octets_s1),
		.res    (div)
	);

	phb_hdr u_hdr_prim (
		.octets (octets_s1),
		.info   (prim_info),
		.div    (div),
		.header (prim_header)
	);

	phb_hdr u_hdr_fb (
		.octets (octets_s1),
		.info   (fb_info),
		.div    (div),
		.header (fb_header)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= {1'b0, fb_header, prim_info.fb, prim_header};
			user_s2 <= {bad_rate, (fb_info.kind == KIND_OFDM),
				(prim_info.kind == KIND_OFDM)};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = user_s2;

`ifndef SYNTHESIS
	// A bad rate carries all-zero words
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0)
		else $error("bad rate with non-zero header data");

	// Fallback is OFDM only when the given rate is OFDM
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
		else $error("OFDM fallback below a CCK rate");

	// OFDM header leaves the upper bits and bit 4 clear
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[31:17] == 15'd0 && !m_axis_tdata[4])
		else $error("OFDM header has stray bits");

	// Input stalls only with both stages full and the output blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with room in the pipeline");
`endif

endmodule
